// ===== sv/cdo_pkg.sv =====
// Shared widths and calendar helper functions for the date offset block.
`timescale 1ns / 1ps

package cdo_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 12;
  localparam int OFF_W  = 17;
  localparam int DIFF_W = 17;
  // Day counts up to 499 years of the Gregorian calendar fit in 18 bits.
  localparam int CNT_W  = 18;

  localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

  // Century years from 1601 to 2099 that are not leap years.
  localparam logic [YEAR_W-1:0] CENTURY_1700 = 12'd1700;
  localparam logic [YEAR_W-1:0] CENTURY_1800 = 12'd1800;
  localparam logic [YEAR_W-1:0] CENTURY_1900 = 12'd1900;

  // Leap year rule, exact for the years 1601 to 2099.
  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic by_four;
    by_four = (y[1:0] == 2'b00);
    return by_four && (y != CENTURY_1700) && (y != CENTURY_1800) && (y != CENTURY_1900);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic [DAY_W-1:0]  d,
                                   input logic [MON_W-1:0]  m,
                                   input logic [YEAR_W-1:0] y,
                                   input logic [YEAR_W-1:0] lo,
                                   input logic [YEAR_W-1:0] hi);
    logic in_range;
    in_range = (y >= lo) && (y <= hi) && (m >= MONTH_JAN) && (m <= MONTH_DEC);
    return in_range && (d != '0) && (d <= month_len(m, leap_year(y)));
  endfunction

endpackage

// ===== sv/cdo_in_if.sv =====
// Input channel: two dates and a signed day offset with valid/ready.
`timescale 1ns / 1ps

interface cdo_in_if import cdo_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [DAY_W-1:0]        first_day;
  logic [MON_W-1:0]        first_month;
  logic [YEAR_W-1:0]       first_year;
  logic signed [OFF_W-1:0] offset_days;
  logic [DAY_W-1:0]        second_day;
  logic [MON_W-1:0]        second_month;
  logic [YEAR_W-1:0]       second_year;

  modport source (output valid, first_day, first_month, first_year, offset_days,
                  second_day, second_month, second_year, input ready);
  modport sink   (input valid, first_day, first_month, first_year, offset_days,
                  second_day, second_month, second_year, output ready);
endinterface

// ===== sv/cdo_out_if.sv =====
// Output channel: shifted date, day difference and status flags with valid/ready.
`timescale 1ns / 1ps

interface cdo_out_if import cdo_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [DAY_W-1:0]         shifted_day;
  logic [MON_W-1:0]         shifted_month;
  logic [YEAR_W-1:0]        shifted_year;
  logic signed [DIFF_W-1:0] day_difference;
  logic                     first_valid;
  logic                     second_valid;
  logic                     underflow;
  logic                     overflow;

  modport source (output valid, shifted_day, shifted_month, shifted_year, day_difference,
                  first_valid, second_valid, underflow, overflow, input ready);
  modport sink   (input valid, shifted_day, shifted_month, shifted_year, day_difference,
                  first_valid, second_valid, underflow, overflow, output ready);
endinterface

// ===== sv/calendar_date_day_offset.sv =====
// Top level: microcoded Gregorian date shifter and date difference unit.
//
//   Channel  Direction  Handshake      Payload
//   req      in         valid / ready  first date, offset_days, second date
//   rsp      out        valid / ready  shifted date, day_difference, flags
//
// Sequence: after a request transfer, each of the two input dates and then the shifted
// date is walked from 1.1.FIRST_YEAR, first by years and then by months, before the
// result is written to the output register. A new request is taken only in the wait
// step, once the previous item has been handed to the output register.
// Reset: rst is synchronous; it returns the sequencer to its wait step and drops rsp.valid.
// Stalls: a finished result sits in the output register, and the next item is accepted
// and converted while it waits; the sequencer only holds in its final step until
// the previous result has been transferred.
`timescale 1ns / 1ps

module calendar_date_day_offset import cdo_pkg::*; #(
  parameter int FIRST_YEAR = 1970,
  parameter int LAST_YEAR  = 2099
) (
  input  logic      clk,
  input  logic      rst,
  cdo_in_if.sink    req,
  cdo_out_if.source rsp
);

  localparam logic [YEAR_W-1:0] FY = YEAR_W'(FIRST_YEAR);
  localparam logic [YEAR_W-1:0] LY = YEAR_W'(LAST_YEAR);

  // Day count of 31.12.LAST_YEAR counted from 1.1.FIRST_YEAR.
  localparam int LastCnt = 365 * (LAST_YEAR - FIRST_YEAR + 1)
                         + (LAST_YEAR / 4 - (FIRST_YEAR - 1) / 4)
                         - (LAST_YEAR / 100 - (FIRST_YEAR - 1) / 100)
                         + (LAST_YEAR / 400 - (FIRST_YEAR - 1) / 400) - 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LastCnt);

  // Microcode word. When the condition holds, the exit action runs and the program
  // jumps to nxt; otherwise the loop action runs and the step repeats.
  typedef struct packed {
    logic [2:0] cond;
    logic [2:0] loop_op;
    logic [2:0] exit_op;
    logic [3:0] nxt;
  } ctrl_t;

  localparam logic [2:0] C_ALWAYS   = 3'd0;
  localparam logic [2:0] C_START    = 3'd1;
  localparam logic [2:0] C_YEAR_HIT = 3'd2;
  localparam logic [2:0] C_MON_HIT  = 3'd3;
  localparam logic [2:0] C_YEAR_FIT = 3'd4;
  localparam logic [2:0] C_MON_FIT  = 3'd5;
  localparam logic [2:0] C_OUT_FREE = 3'd6;

  localparam logic [2:0] L_NONE     = 3'd0;
  localparam logic [2:0] L_YEAR_ADD = 3'd1;
  localparam logic [2:0] L_MON_ADD  = 3'd2;
  localparam logic [2:0] L_YEAR_SUB = 3'd3;
  localparam logic [2:0] L_MON_SUB  = 3'd4;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_LOAD     = 3'd1;
  localparam logic [2:0] E_COUNT1   = 3'd2;
  localparam logic [2:0] E_COUNT2   = 3'd3;
  localparam logic [2:0] E_SHIFT    = 3'd4;
  localparam logic [2:0] E_OUT      = 3'd5;

  localparam logic [3:0] P_IDLE     = 4'd0;
  localparam logic [3:0] P_Y1       = 4'd1;
  localparam logic [3:0] P_M1       = 4'd2;
  localparam logic [3:0] P_D1       = 4'd3;
  localparam logic [3:0] P_Y2       = 4'd4;
  localparam logic [3:0] P_M2       = 4'd5;
  localparam logic [3:0] P_D2       = 4'd6;
  localparam logic [3:0] P_SHIFT    = 4'd7;
  localparam logic [3:0] P_YB       = 4'd8;
  localparam logic [3:0] P_MB       = 4'd9;
  localparam logic [3:0] P_OUT      = 4'd10;

  // The program. Both dates walk up from 1.1.FIRST_YEAR, adding year then month
  // lengths until the target is reached; the shifted count is then walked down.
  function automatic ctrl_t rom_word(input logic [3:0] a);
    ctrl_t w;
    unique case (a)
      P_IDLE:  w = '{cond: C_START,    loop_op: L_NONE,     exit_op: E_LOAD,   nxt: P_Y1};
      P_Y1:    w = '{cond: C_YEAR_HIT, loop_op: L_YEAR_ADD, exit_op: E_NONE,   nxt: P_M1};
      P_M1:    w = '{cond: C_MON_HIT,  loop_op: L_MON_ADD,  exit_op: E_NONE,   nxt: P_D1};
      P_D1:    w = '{cond: C_ALWAYS,   loop_op: L_NONE,     exit_op: E_COUNT1, nxt: P_Y2};
      P_Y2:    w = '{cond: C_YEAR_HIT, loop_op: L_YEAR_ADD, exit_op: E_NONE,   nxt: P_M2};
      P_M2:    w = '{cond: C_MON_HIT,  loop_op: L_MON_ADD,  exit_op: E_NONE,   nxt: P_D2};
      P_D2:    w = '{cond: C_ALWAYS,   loop_op: L_NONE,     exit_op: E_COUNT2, nxt: P_SHIFT};
      P_SHIFT: w = '{cond: C_ALWAYS,   loop_op: L_NONE,     exit_op: E_SHIFT,  nxt: P_YB};
      P_YB:    w = '{cond: C_YEAR_FIT, loop_op: L_YEAR_SUB, exit_op: E_NONE,   nxt: P_MB};
      P_MB:    w = '{cond: C_MON_FIT,  loop_op: L_MON_SUB,  exit_op: E_NONE,   nxt: P_OUT};
      P_OUT:   w = '{cond: C_OUT_FREE, loop_op: L_NONE,     exit_op: E_OUT,    nxt: P_IDLE};
      default: w = '{cond: C_ALWAYS,   loop_op: L_NONE,     exit_op: E_NONE,   nxt: P_IDLE};
    endcase
    return w;
  endfunction

  // Sequencer and datapath registers.
  logic [3:0]              pc;
  logic [CNT_W-1:0]        acc;
  logic [YEAR_W-1:0]       wy;
  logic [MON_W-1:0]        wm;
  logic [DAY_W-1:0]        td;
  logic [MON_W-1:0]        tm;
  logic [YEAR_W-1:0]       ty;
  logic [DAY_W-1:0]        d2;
  logic [MON_W-1:0]        m2;
  logic [YEAR_W-1:0]       y2;
  logic signed [OFF_W-1:0] off;
  logic [CNT_W-1:0]        c1;
  logic [CNT_W-1:0]        c2;
  logic [DIFF_W-1:0]       diff;
  logic                    v1;
  logic                    v2;
  logic                    uf;
  logic                    of;

  // Output register.
  logic                    out_valid;
  logic [DAY_W-1:0]        out_day;
  logic [MON_W-1:0]        out_month;
  logic [YEAR_W-1:0]       out_year;
  logic [DIFF_W-1:0]       out_diff;
  logic                    out_v1;
  logic                    out_v2;
  logic                    out_uf;
  logic                    out_of;

  ctrl_t                   cw;
  logic                    cond_hit;
  logic                    out_load;
  logic                    wy_leap;
  logic [8:0]              ylen;
  logic [DAY_W-1:0]        mlen;
  logic                    in_ok1;
  logic                    in_ok2;
  logic signed [CNT_W+1:0] total;
  logic                    total_neg;
  logic                    total_big;
  logic [CNT_W-1:0]        count_sub;

  assign cw      = rom_word(pc);
  assign wy_leap = leap_year(wy);
  assign ylen    = wy_leap ? 9'd366 : 9'd365;
  assign mlen    = month_len(wm, wy_leap);

  assign in_ok1 = date_ok(req.first_day, req.first_month, req.first_year, FY, LY);
  assign in_ok2 = date_ok(req.second_day, req.second_month, req.second_year, FY, LY);

  // Shifted day count with its range check, and the date difference.
  assign total     = $signed({2'b00, c1}) + (CNT_W + 2)'(off);
  assign total_neg = total < 0;
  assign total_big = total > $signed({2'b00, LAST_CNT});
  assign count_sub = c1 - c2;

  always_comb begin
    unique case (cw.cond)
      C_START:    cond_hit = req.valid;
      C_YEAR_HIT: cond_hit = (wy == ty);
      C_MON_HIT:  cond_hit = (wm == tm);
      C_YEAR_FIT: cond_hit = (wy == LY) || (acc < CNT_W'(ylen));
      C_MON_FIT:  cond_hit = (wm == MONTH_DEC) || (acc < CNT_W'(mlen));
      C_OUT_FREE: cond_hit = !out_valid || rsp.ready;
      default:    cond_hit = 1'b1;
    endcase
  end

  // A new result enters the output register when it is empty or in the same cycle that the old one leaves.
  assign out_load = cond_hit && (cw.exit_op == E_OUT);

  assign req.ready = (pc == P_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= P_IDLE;
      out_valid <= 1'b0;
      wy        <= FY;
      wm        <= MONTH_JAN;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (cond_hit) begin
        pc <= cw.nxt;
        unique case (cw.exit_op)
          E_LOAD: begin
            // Invalid dates are replaced by 1.1.FIRST_YEAR.
            v1  <= in_ok1;
            v2  <= in_ok2;
            td  <= in_ok1 ? req.first_day   : DAY_W'(1);
            tm  <= in_ok1 ? req.first_month : MONTH_JAN;
            ty  <= in_ok1 ? req.first_year  : FY;
            d2  <= in_ok2 ? req.second_day   : DAY_W'(1);
            m2  <= in_ok2 ? req.second_month : MONTH_JAN;
            y2  <= in_ok2 ? req.second_year  : FY;
            off <= req.offset_days;
            acc <= '0;
            wy  <= FY;
            wm  <= MONTH_JAN;
          end
          E_COUNT1: begin
            c1  <= acc + CNT_W'(td) - CNT_W'(1);
            td  <= d2;
            tm  <= m2;
            ty  <= y2;
            acc <= '0;
            wy  <= FY;
            wm  <= MONTH_JAN;
          end
          E_COUNT2: begin
            c2 <= acc + CNT_W'(td) - CNT_W'(1);
          end
          E_SHIFT: begin
            // Latch the difference, clamp to the calendar range and flag which side was hit.
            uf   <= total_neg;
            of   <= total_big && !total_neg;
            diff <= count_sub[DIFF_W-1:0];
            if (total_neg) begin
              acc <= '0;
            end else if (total_big) begin
              acc <= LAST_CNT;
            end else begin
              acc <= total[CNT_W-1:0];
            end
            wy <= FY;
            wm <= MONTH_JAN;
          end
          E_OUT: begin
            out_day   <= acc[DAY_W-1:0] + DAY_W'(1);
            out_month <= wm;
            out_year  <= wy;
            out_diff  <= diff;
            out_v1    <= v1;
            out_v2    <= v2;
            out_uf    <= uf;
            out_of    <= of;
          end
          default: begin
          end
        endcase
      end else begin
        unique case (cw.loop_op)
          L_YEAR_ADD: begin
            acc <= acc + CNT_W'(ylen);
            wy  <= wy + YEAR_W'(1);
          end
          L_MON_ADD: begin
            acc <= acc + CNT_W'(mlen);
            wm  <= wm + MON_W'(1);
          end
          L_YEAR_SUB: begin
            acc <= acc - CNT_W'(ylen);
            wy  <= wy + YEAR_W'(1);
          end
          L_MON_SUB: begin
            acc <= acc - CNT_W'(mlen);
            wm  <= wm + MON_W'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.shifted_day    = out_day;
  assign rsp.shifted_month  = out_month;
  assign rsp.shifted_year   = out_year;
  assign rsp.day_difference = $signed(out_diff);
  assign rsp.first_valid    = out_v1;
  assign rsp.second_valid   = out_v2;
  assign rsp.underflow      = out_uf;
  assign rsp.overflow       = out_of;

  // The month walker never leaves January to December.
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (wm >= MONTH_JAN) && (wm <= MONTH_DEC))
    else $error("month walker out of range");

  // The year walker never passes the last calendar year.
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (wy >= FY) && (wy <= LY))
    else $error("year walker out of range");

  // A new result only appears after the final program step.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == P_OUT)
    else $error("result raised outside the output step");

  // A clamped result sits exactly on the matching calendar end.
  a_underflow_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_uf) |-> (!out_of && out_day == DAY_W'(1) && out_month == MONTH_JAN
                               && out_year == FY))
    else $error("underflow result not at the first day");

  a_overflow_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of) |-> (out_day == DAY_W'(31) && out_month == MONTH_DEC
                               && out_year == LY))
    else $error("overflow result not at the last day");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the Gregorian date shifter: directed calendar edges, then random date pairs.
`timescale 1ns / 1ps

module tb_top import cdo_pkg::*;;

  // Calendar range used both by the block and by the predictor below.
  localparam int CAL_FIRST_YEAR = 1970;
  localparam int CAL_LAST_YEAR  = 2099;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The limit leaves a wide margin over the slowest item plus the longest idle
  // gap on each side.
  localparam int STALL_LIMIT = 5000;
  // Quiet period after the last expected result, about one worst-case item.
  localparam int SETTLE_CYCLES = 450;

  localparam int BURST_ITEMS  = 100;
  localparam int RANDOM_ITEMS = 850;

  // One request transfer: two dates and the signed offset for the first one.
  typedef struct {
    logic [DAY_W-1:0]        first_day;
    logic [MON_W-1:0]        first_month;
    logic [YEAR_W-1:0]       first_year;
    logic signed [OFF_W-1:0] offset_days;
    logic [DAY_W-1:0]        second_day;
    logic [MON_W-1:0]        second_month;
    logic [YEAR_W-1:0]       second_year;
  } date_req_t;

  // One response transfer as the predictor expects it.
  typedef struct {
    logic [DAY_W-1:0]         shifted_day;
    logic [MON_W-1:0]         shifted_month;
    logic [YEAR_W-1:0]        shifted_year;
    logic signed [DIFF_W-1:0] day_difference;
    logic                     first_valid;
    logic                     second_valid;
    logic                     underflow;
    logic                     overflow;
  } shift_result_t;

  typedef struct {
    logic [DAY_W-1:0]  d;
    logic [MON_W-1:0]  m;
    logic [YEAR_W-1:0] y;
  } cal_date_t;

  logic clk = 1'b0;
  logic rst;

  cdo_in_if  req_if ();
  cdo_out_if rsp_if ();

  calendar_date_day_offset #(
    .FIRST_YEAR(CAL_FIRST_YEAR),
    .LAST_YEAR (CAL_LAST_YEAR)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results still owed by the block, oldest first.
  shift_result_t expected_shifts[$];
  int            mismatch_count = 0;
  // When set, neither side inserts idle cycles.
  bit            full_speed = 1'b0;
  // Cycles left before the response side reconsiders its ready level.
  int            sink_hold = 0;
  shift_result_t want;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the predictor.
  // ---------------------------------------------------------------------------

  function automatic bit is_leap(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int month_days(input int m, input int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int year_days(input int y);
    return is_leap(y) ? 366 : 365;
  endfunction

  // A date is usable only inside the calendar range and with a real day of a real month.
  function automatic bit calendar_date_ok(input int d, input int m, input int y);
    if (y < CAL_FIRST_YEAR || y > CAL_LAST_YEAR) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_days(m, y));
  endfunction

  // Days elapsed since 1 January of the first calendar year.
  function automatic int epoch_days(input int d, input int m, input int y);
    int count;
    count = 0;
    for (int yr = CAL_FIRST_YEAR; yr < y; yr++) count += year_days(yr);
    for (int mo = 1; mo < m; mo++) count += month_days(mo, y);
    return count + d - 1;
  endfunction

  // Inverse of epoch_days; the count must already be clamped to the range.
  function automatic void count_to_calendar(input int count, output int d, output int m,
                                            output int y);
    int rest;
    rest = count;
    y = CAL_FIRST_YEAR;
    m = 1;
    while (y < CAL_LAST_YEAR && rest >= year_days(y)) begin
      rest -= year_days(y);
      y++;
    end
    while (m < 12 && rest >= month_days(m, y)) begin
      rest -= month_days(m, y);
      m++;
    end
    d = rest + 1;
  endfunction

  // Expected response for one request: both dates are sanitized, the first one
  // is moved and clamped, and the difference wraps to the output width.
  function automatic shift_result_t predict_shift(input date_req_t r);
    shift_result_t res;
    int d1, m1, y1, d2, m2, y2;
    int first_count, second_count, target, last_count;
    int sd, sm, sy;
    d1 = r.first_day;
    m1 = r.first_month;
    y1 = r.first_year;
    d2 = r.second_day;
    m2 = r.second_month;
    y2 = r.second_year;
    res.first_valid  = calendar_date_ok(d1, m1, y1);
    res.second_valid = calendar_date_ok(d2, m2, y2);
    if (!res.first_valid) begin
      d1 = 1;
      m1 = 1;
      y1 = CAL_FIRST_YEAR;
    end
    if (!res.second_valid) begin
      d2 = 1;
      m2 = 1;
      y2 = CAL_FIRST_YEAR;
    end
    first_count  = epoch_days(d1, m1, y1);
    second_count = epoch_days(d2, m2, y2);
    last_count   = epoch_days(31, 12, CAL_LAST_YEAR);
    target = first_count + $signed(r.offset_days);
    res.underflow = (target < 0);
    res.overflow  = (target > last_count);
    if (res.underflow) target = 0;
    else if (res.overflow) target = last_count;
    count_to_calendar(target, sd, sm, sy);
    res.shifted_day    = DAY_W'(sd);
    res.shifted_month  = MON_W'(sm);
    res.shifted_year   = YEAR_W'(sy);
    res.day_difference = DIFF_W'(first_count - second_count);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (full_speed || roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic date_req_t make_request(input int d1, input int m1, input int y1,
                                             input int off, input int d2, input int m2,
                                             input int y2);
    date_req_t r;
    r.first_day    = DAY_W'(d1);
    r.first_month  = MON_W'(m1);
    r.first_year   = YEAR_W'(y1);
    r.offset_days  = OFF_W'(off);
    r.second_day   = DAY_W'(d2);
    r.second_month = MON_W'(m2);
    r.second_year  = YEAR_W'(y2);
    return r;
  endfunction

  // Most dates are valid with random content, some sit at the ends of the range,
  // some are one day past their month, and the rest are raw bit patterns.
  function automatic cal_date_t pick_date();
    cal_date_t dt;
    int roll, yr;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      dt.d = DAY_W'($urandom);
      dt.m = MON_W'($urandom);
      dt.y = YEAR_W'($urandom);
    end else begin
      if (roll < 40) begin
        yr = $urandom_range(0, 1) ? CAL_FIRST_YEAR + $urandom_range(0, 3)
                                  : CAL_LAST_YEAR - $urandom_range(0, 3);
      end else begin
        yr = $urandom_range(CAL_FIRST_YEAR, CAL_LAST_YEAR);
      end
      dt.y = YEAR_W'(yr);
      dt.m = MON_W'($urandom_range(1, 12));
      if (roll < 25) dt.d = DAY_W'(month_days(dt.m, yr) + 1);
      else dt.d = DAY_W'($urandom_range(1, month_days(dt.m, yr)));
    end
    return dt;
  endfunction

  // Offsets: small steps, raw 17-bit patterns, anything within the range, and
  // values aimed at either end of the calendar from the given first date.
  function automatic logic signed [OFF_W-1:0] pick_offset(input cal_date_t first);
    int roll, base, span, off;
    roll = $urandom_range(0, 99);
    span = epoch_days(31, 12, CAL_LAST_YEAR);
    base = calendar_date_ok(first.d, first.m, first.y) ? epoch_days(first.d, first.m, first.y)
                                                       : 0;
    if (roll < 35) off = int'($urandom_range(0, 800)) - 400;
    else if (roll < 60) off = $urandom;
    else if (roll < 75) off = int'($urandom_range(0, 2 * span)) - span;
    else if (roll < 88) off = -base + int'($urandom_range(0, 6)) - 3;
    else off = span - base + int'($urandom_range(0, 6)) - 3;
    return OFF_W'(off);
  endfunction

  function automatic date_req_t random_request();
    cal_date_t a, b;
    a = pick_date();
    b = ($urandom_range(0, 9) == 0) ? a : pick_date();
    return make_request(a.d, a.m, a.y, pick_offset(a), b.d, b.m, b.y);
  endfunction

  // Offer one request and wait for its transfer. Called at a rising edge; when
  // no gap is chosen, valid stays high and only the payload changes.
  task automatic send_dates(input date_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.first_day    <= r.first_day;
    req_if.first_month  <= r.first_month;
    req_if.first_year   <= r.first_year;
    req_if.offset_days  <= r.offset_days;
    req_if.second_day   <= r.second_day;
    req_if.second_month <= r.second_month;
    req_if.second_year  <= r.second_year;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_shifts.push_back(predict_shift(r));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Field extremes, leap days, every kind of invalid date, both clamps and the
  // exact ends of the calendar.
  task automatic test_calendar_edges();
    int span;
    span = epoch_days(31, 12, CAL_LAST_YEAR);
    send_dates(make_request(1, MONTH_JAN, CAL_FIRST_YEAR, 0, 1, MONTH_JAN, CAL_FIRST_YEAR));
    send_dates(make_request(31, MONTH_DEC, CAL_LAST_YEAR, 0, 1, MONTH_JAN, CAL_FIRST_YEAR));
    send_dates(make_request(1, MONTH_JAN, CAL_FIRST_YEAR, 0, 31, MONTH_DEC, CAL_LAST_YEAR));
    // Leap days: 2000 is a leap century, 2001 is not a leap year at all.
    send_dates(make_request(29, 2, 2000, 1, 28, 2, 2000));
    send_dates(make_request(29, 2, 2001, 5, 29, 2, 1972));
    send_dates(make_request(1, 3, 2000, -1, 29, 2, 2096));
    send_dates(make_request(31, 12, 1999, 1, 1, 1, 2000));
    // Years just outside the range and raw extremes of every field.
    send_dates(make_request(28, 2, CAL_LAST_YEAR + 1, 3, 15, 6, CAL_FIRST_YEAR - 1));
    send_dates(make_request(0, 0, 0, -1, 0, 0, 0));
    send_dates(make_request(31, 15, 4095, 65535, 31, 15, 4095));
    // Day zero, a 31st in a 30-day month, month thirteen.
    send_dates(make_request(0, 5, 2020, 10, 31, 4, 2020));
    send_dates(make_request(1, 13, 2020, -10, 31, 11, 2050));
    // Shifts past either end clamp and raise a flag; the exact ends do not.
    send_dates(make_request(1, MONTH_JAN, CAL_FIRST_YEAR, -65536, 2, 1, 1970));
    send_dates(make_request(1, MONTH_JAN, CAL_FIRST_YEAR, -1, 1, 1, 2099));
    send_dates(make_request(31, MONTH_DEC, CAL_LAST_YEAR, 1, 30, 12, 2099));
    send_dates(make_request(1, MONTH_JAN, CAL_FIRST_YEAR, span, 31, 1, 2099));
    send_dates(make_request(31, MONTH_DEC, CAL_LAST_YEAR, -span, 1, 7, 2035));
    send_dates(make_request(30, 11, 2050, 31, 31, 12, 2050));
    send_dates(make_request(31, 1, 2099, 0, 31, 12, 2099));
    send_dates(make_request(15, 8, 2040, 65535, 15, 8, 2040));
  endtask

  // Random requests with both sides running flat out.
  task automatic test_back_to_back(input int count);
    full_speed = 1'b1;
    for (int i = 0; i < count; i++) send_dates(random_request());
    full_speed = 1'b0;
  endtask

  // Random requests with random idle gaps on both channels.
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) send_dates(random_request());
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random ready pattern and the checker.
  // ---------------------------------------------------------------------------

  // Ready alternates between runs high and stalls; a zero-length stall simply
  // extends the current run.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      sink_hold = 0;
    end else if (full_speed) begin
      rsp_if.ready <= 1'b1;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end else if (rsp_if.ready) begin
      sink_hold = pick_gap();
      if (sink_hold == 0) begin
        sink_hold = $urandom_range(1, 8);
      end else begin
        rsp_if.ready <= 1'b0;
        sink_hold--;
      end
    end else begin
      rsp_if.ready <= 1'b1;
      sink_hold = $urandom_range(0, 12);
    end
  end

  task automatic compare_field(input string field, input logic signed [31:0] expected_val,
                               input logic signed [31:0] actual_val);
    if (actual_val !== expected_val) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, expected_val, actual_val);
      mismatch_count++;
    end
  endtask

  // Every response transfer is matched against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_shifts.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %0d.%0d.%0d diff %0d",
                 $time, rsp_if.shifted_day, rsp_if.shifted_month, rsp_if.shifted_year,
                 rsp_if.day_difference);
        mismatch_count++;
      end else begin
        want = expected_shifts.pop_front();
        compare_field("shifted_day", want.shifted_day, rsp_if.shifted_day);
        compare_field("shifted_month", want.shifted_month, rsp_if.shifted_month);
        compare_field("shifted_year", want.shifted_year, rsp_if.shifted_year);
        compare_field("day_difference", want.day_difference, rsp_if.day_difference);
        compare_field("first_valid", want.first_valid, rsp_if.first_valid);
        compare_field("second_valid", want.second_valid, rsp_if.second_valid);
        compare_field("underflow", want.underflow, rsp_if.underflow);
        compare_field("overflow", want.overflow, rsp_if.overflow);
      end
    end
  end

  // Hang detection: too many consecutive cycles without a transfer on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------

  initial begin
    rst                 = 1'b1;
    req_if.valid        = 1'b0;
    req_if.first_day    = '0;
    req_if.first_month  = '0;
    req_if.first_year   = '0;
    req_if.offset_days  = '0;
    req_if.second_day   = '0;
    req_if.second_month = '0;
    req_if.second_year  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_calendar_edges();
    test_back_to_back(BURST_ITEMS);
    test_random_mix(RANDOM_ITEMS);

    req_if.valid <= 1'b0;
    // Let every outstanding result drain, then watch for stray transfers.
    while (expected_shifts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_shifts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cdo_pkg.sv
sv/cdo_in_if.sv
sv/cdo_out_if.sv
sv/calendar_date_day_offset.sv
dv/tb_top.sv
